// ===== rtl/mtf_pkg.sv =====
`timescale 1ns / 1ps

package mtf_pkg;

  // width of the key, count and register fields on the ports
  localparam int KEY_W = 7;

  // operation codes carried on func
  localparam logic FUNC_ACCESS = 1'b0;
  localparam logic FUNC_DUMP   = 1'b1;

  // result status codes
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  // per-cycle commands broadcast along the row of cells
  typedef struct packed {
    logic load;    // reload the initial order
    logic cmp;     // compare the held key with the accessed key
    logic move;    // shift towards the back, behind the accessed key
    logic rotate;  // rotate the active part of the row by one place
  } cell_ctl_t;

endpackage

// ===== rtl/mtf_cell.sv =====
`timescale 1ns / 1ps

module mtf_cell
  import mtf_pkg::*;
#(
  parameter int IW = 6
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic [IW-1:0] init_val,
  input  logic          init_act,
  input  logic          init_tail,
  input  logic [IW-1:0] key_idx,
  input  logic          key_ok,
  input  logic          span,
  input  logic [IW-1:0] left_val,
  input  logic [IW-1:0] right_val,
  input  logic [IW-1:0] head_val,
  output logic [IW-1:0] val,
  output logic          match
);

  logic act;
  logic tail;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val  <= init_val;
      act  <= init_act;
      tail <= init_tail;
    end else if (ctl.move && span) begin
      val <= left_val;
    end else if (ctl.rotate && act) begin
      val <= tail ? head_val : right_val;
    end
  end

  // match flag is held until the next compare
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      match <= key_ok && (val == key_idx);
    end
  end

endmodule

// ===== rtl/move_to_front_recency_list_top.sv =====
`timescale 1ns / 1ps

// move-to-front recency list over keys 1..n. the order lives in a row of
// MAX_ENTRIES cells, cell 0 holding the most recent key. an access word
// (func 0) is worked on in steps: the word is latched at
// acceptance, every cell compares its key, a registered suffix-or marks the
// cells in front of the hit, and those cells shift back by one while the
// accessed key drops into cell 0; the result enters the output register
// with that shift. an out-of-range key (0 or above n) hits
// no cell, leaves the order alone and returns status 1. a dump word
// (func 1) returns n words, one per cycle while the output is taken, by
// rotating the first n cells one place a cycle and reading cell 0; after n
// steps the row is back where it started. a full, untaken output
// register holds either kind of word back for as long as it stays
// stalled. one word is worked on at a time; a new word is taken while the
// previous result still sits in the output register. writing cfg_data
// (clamped to 1..MAX_ENTRIES) reloads the order 1..n in the same
// cycle

module move_to_front_recency_list_top
  import mtf_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [KEY_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             func,
  input  logic [KEY_W-1:0] key,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [KEY_W-1:0] out_key,
  output logic             last,
  output logic             status
);

  localparam int IW = $clog2(MAX_ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_SPAN = 5'b00100,
    S_MOVE = 5'b01000,
    S_DUMP = 5'b10000
  } state_t;

  state_t state;

  // number of keys in use
  logic [KEY_W-1:0] n_entries;
  logic [KEY_W-1:0] n_load;

  // latched word
  logic [KEY_W-1:0] key_r;
  logic [IW-1:0]    key_idx_r;
  logic             key_ok_r;

  // dump position
  logic [KEY_W-1:0] dump_cursor;

  // row signals
  cell_ctl_t           ctl;
  logic [IW-1:0]       vals  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] hit_flags;
  logic [MAX_ENTRIES-1:0] span_r;
  logic [MAX_ENTRIES-1:0] span_next;

  logic slot_free;
  logic dump_last;
  logic key_ok;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign dump_last = (dump_cursor == n_entries - KEY_W'(1));
  assign key_ok    = (key != '0) && (key <= n_entries);

  // clamp a written count to 1..MAX_ENTRIES; reset loads the full row
  always_comb begin
    if (rst) begin
      n_load = KEY_W'(MAX_ENTRIES);
    end else if (cfg_data == '0) begin
      n_load = KEY_W'(1);
    end else if (cfg_data > KEY_W'(MAX_ENTRIES)) begin
      n_load = KEY_W'(MAX_ENTRIES);
    end else begin
      n_load = cfg_data;
    end
  end

  always_comb begin
    ctl.load   = rst || cfg_we;
    ctl.cmp    = (state == S_CMP);
    ctl.move   = (state == S_MOVE) && slot_free;
    ctl.rotate = (state == S_DUMP) && slot_free;
  end

  // cells at or in front of the hit move back: suffix-or by doubling
  always_comb begin
    span_next = hit_flags;
    for (int k = 0; k < IW; k++) begin
      span_next = span_next | (span_next >> (1 << k));
    end
  end

  // row of cells
  for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
    logic [IW-1:0] left_in;
    logic [IW-1:0] right_in;

    if (j == 0) begin : g_head
      assign left_in = key_idx_r;
    end else begin : g_body
      assign left_in = vals[j-1];
    end

    if (j == MAX_ENTRIES - 1) begin : g_end
      assign right_in = vals[0];
    end else begin : g_mid
      assign right_in = vals[j+1];
    end

    mtf_cell #(
      .IW (IW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .init_val  (IW'(j)),
      .init_act  (KEY_W'(j) < n_load),
      .init_tail (KEY_W'(j) == n_load - KEY_W'(1)),
      .key_idx   (key_idx_r),
      .key_ok    (key_ok_r),
      .span      (span_r[j]),
      .left_val  (left_in),
      .right_val (right_in),
      .head_val  (vals[0]),
      .val       (vals[j]),
      .match     (hit_flags[j])
    );
  end

  // count register
  always_ff @(posedge clk) begin
    if (rst) begin
      n_entries <= KEY_W'(MAX_ENTRIES);
    end else if (cfg_we) begin
      n_entries <= n_load;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      dump_cursor <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state       <= (func == FUNC_DUMP) ? S_DUMP : S_CMP;
            dump_cursor <= '0;
          end
        end
        S_CMP: begin
          state <= S_SPAN;
        end
        S_SPAN: begin
          state <= S_MOVE;
        end
        S_MOVE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        S_DUMP: begin
          if (slot_free) begin
            if (dump_last) begin
              state       <= S_IDLE;
              dump_cursor <= '0;
            end else begin
              dump_cursor <= dump_cursor + KEY_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // latched word and span flags
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_r     <= key;
      key_idx_r <= IW'(key - KEY_W'(1));
      key_ok_r  <= key_ok;
    end
    if (state == S_SPAN) begin
      span_r <= span_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.move || ctl.rotate) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.move) begin
      out_key <= key_r;
      last    <= 1'b1;
      status  <= key_ok_r ? ST_OK : ST_RANGE;
    end else if (ctl.rotate) begin
      out_key <= KEY_W'(vals[0]) + KEY_W'(1);
      last    <= dump_last;
      status  <= ST_OK;
    end
  end

endmodule

// ===== rtl/mtf_checker.sv =====
`timescale 1ns / 1ps

module mtf_checker
  import mtf_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [KEY_W-1:0] out_key,
  input logic             last,
  input logic             status
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(last)
      && $stable(status))
    else $error("result word changed while stalled");

  // a rejected key always closes its word
  a_bad_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_RANGE |-> last)
    else $error("flagged result not marked last");

  // a good result never carries key zero
  a_key_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> out_key != '0)
    else $error("good result with key zero");

  // one word at a time: busy right after an acceptance
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted back to back");

endmodule

bind move_to_front_recency_list_top mtf_checker u_mtf_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench
  import mtf_pkg::*;
();

  localparam int MAX_KEYS       = 64;
  localparam int STALL_LIMIT    = 2000;  // cycles with no word moving on either side
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int PHASES         = 11;
  localparam int WORDS_PER_PHASE = 26;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
    logic             status;
  } result_word_t;

  // tracks the recency order and the result words still owed by the block
  class recency_tracker;
    int unsigned      n_keys;
    logic [KEY_W-1:0] order[$];  // most recent first
    result_word_t     due[$];
    int unsigned      errors;

    function new();
      errors = 0;
      load(7'(MAX_KEYS));
    endfunction

    // clamp and reload the order 1..n
    function void load(logic [KEY_W-1:0] v);
      n_keys = (v == 0) ? 1 : ((v > MAX_KEYS) ? MAX_KEYS : v);
      order.delete();
      for (int i = 1; i <= n_keys; i++) order.push_back(KEY_W'(i));
    endfunction

    function int pending();
      return due.size();
    endfunction

    // an accepted input word: update the order and queue its results
    function void note_word(logic f, logic [KEY_W-1:0] k);
      result_word_t r;
      if (f == FUNC_ACCESS) begin
        r.key = k;
        r.last = 1'b1;
        r.status = (k == 0 || k > n_keys) ? ST_RANGE : ST_OK;
        if (r.status == ST_OK) begin
          for (int i = 0; i < order.size(); i++) begin
            if (order[i] == k) begin
              order.delete(i);
              break;
            end
          end
          order.push_front(k);
        end
        due.push_back(r);
      end else begin
        for (int i = 0; i < n_keys; i++) begin
          r.key = order[i];
          r.last = (i == n_keys - 1);
          r.status = ST_OK;
          due.push_back(r);
        end
      end
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // an accepted output word against the oldest expectation
    task check_word(logic [KEY_W-1:0] k, logic l, logic s);
      result_word_t e;
      if (due.size() == 0) begin
        report($sformatf("unexpected word key=%0d last=%0b status=%0b", k, l, s));
      end else begin
        e = due.pop_front();
        if (k !== e.key || l !== e.last || s !== e.status)
          report($sformatf("got key=%0d last=%0b status=%0b, %s",
                           k, l, s,
                           $sformatf("want key=%0d last=%0b status=%0b",
                                     e.key, e.last, e.status)));
      end
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [KEY_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  logic             func;
  logic [KEY_W-1:0] key;
  logic             out_valid;
  logic             out_ready;
  logic [KEY_W-1:0] out_key;
  logic             last;
  logic             status;

  recency_tracker tracker;

  int snd_idle;   // percent of cycles the sender holds back
  int rcv_stall;  // percent of cycles the receiver holds back
  bit hold_req;   // asks the receiver for one long hold-off
  bit hold_done;  // the long hold-off has been served
  int quiet_cycles;

  move_to_front_recency_list_top #(
    .MAX_ENTRIES(MAX_KEYS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .key      (key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_key  (out_key),
    .last     (last),
    .status   (status)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // monitor and watchdog: sample both handshakes at the rising edge; the
  // output is checked before the input is noted, since a word leaving now
  // can never belong to the word being taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid === 1'b1 && out_ready)
        tracker.check_word(out_key, last, status);
      if (in_valid && in_ready === 1'b1)
        tracker.note_word(func, key);
    end
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] timeout: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random back-pressure, plus one long hold-off when asked so
  // that the block fills up and stops taking words
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  // offer one word and hold it until taken; returns at a falling edge
  task send_word(logic f, logic [KEY_W-1:0] k);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    key <= k;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  // wait for the block to drain, then write n_entries; returns at a falling edge
  task write_entries(logic [KEY_W-1:0] v);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (6) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    tracker.load(v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // idling mix: none, sender only, receiver only, both
  task set_idling(int mode);
    case (mode)
      0: begin
        snd_idle = 0;
        rcv_stall = 0;
      end
      1: begin
        snd_idle = 45;
        rcv_stall = 0;
      end
      2: begin
        snd_idle = 0;
        rcv_stall = 45;
      end
      default: begin
        snd_idle = 28;
        rcv_stall = 28;
      end
    endcase
  endtask

  // random word: mostly accesses, biased towards the ends of the order
  task random_word();
    int unsigned      pick;
    logic [KEY_W-1:0] k;
    pick = $urandom_range(99);
    if (pick < 18) begin
      send_word(FUNC_DUMP, KEY_W'($urandom_range(127)));
    end else begin
      pick = $urandom_range(99);
      if (pick < 10)
        k = ($urandom_range(1) == 0) ? 7'd0 : KEY_W'($urandom_range(127, tracker.n_keys + 1));
      else if (pick < 25)
        k = tracker.order[0];
      else if (pick < 40)
        k = tracker.order[tracker.order.size() - 1];
      else
        k = KEY_W'($urandom_range(tracker.n_keys, 1));
      send_word(FUNC_ACCESS, k);
    end
  endtask

  logic [KEY_W-1:0] phase_entries [PHASES] =
    '{7'd3, 7'd8, 7'd64, 7'd5, 7'd1, 7'd12, 7'd65, 7'd20, 7'd0, 7'd2, 7'd127};

  initial begin
    tracker = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    func = FUNC_ACCESS;
    key = '0;
    hold_req = 1'b0;
    set_idling(0);

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: full order after reset, oldest and most recent keys,
    // out-of-range keys at both ends of the field
    send_word(FUNC_DUMP, 7'd0);
    send_word(FUNC_ACCESS, 7'd64);
    send_word(FUNC_ACCESS, 7'd64);
    send_word(FUNC_ACCESS, 7'd1);
    send_word(FUNC_ACCESS, 7'd0);
    send_word(FUNC_ACCESS, 7'd65);
    send_word(FUNC_ACCESS, 7'd127);
    send_word(FUNC_ACCESS, 7'd32);
    send_word(FUNC_DUMP, 7'd127);

    // zero clamps to a single key
    write_entries(7'd0);
    send_word(FUNC_ACCESS, 7'd1);
    send_word(FUNC_ACCESS, 7'd1);
    send_word(FUNC_ACCESS, 7'd2);
    send_word(FUNC_DUMP, 7'd0);

    // two keys: oldest access just rotates the ring
    write_entries(7'd2);
    send_word(FUNC_ACCESS, 7'd2);
    send_word(FUNC_ACCESS, 7'd1);
    send_word(FUNC_ACCESS, 7'd2);
    send_word(FUNC_ACCESS, 7'd3);
    send_word(FUNC_DUMP, 7'd0);

    // all ones saturates to the full row
    write_entries(7'd127);
    send_word(FUNC_ACCESS, 7'd63);
    send_word(FUNC_DUMP, 7'd0);

    // random phases, each with its own key count and idling mix
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 2)
        write_entries(KEY_W'($urandom_range(127)));
      else
        write_entries(phase_entries[ph]);
      set_idling(ph % 4);
      if (ph == 3)
        hold_req = 1'b1;
      repeat (WORDS_PER_PHASE) random_word();
    end
    in_valid <= 1'b0;

    // drain, then allow for a full dump worth of trailing words
    while (tracker.pending() != 0) @(posedge clk);
    repeat (2 * MAX_KEYS + 8) @(posedge clk);

    if (tracker.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mtf_pkg.sv
rtl/mtf_cell.sv
rtl/move_to_front_recency_list_top.sv
rtl/mtf_checker.sv
tb/testbench.sv
